FILE: hdl/gclsp_pkg.sv
// ============================================================================
// gclsp_pkg: shared types and constants for the glyph cache
// Entry layout, cell control word, status codes and the shelf packer step.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package gclsp_pkg;

    localparam int KEY_W   = 21;
    localparam int CRD_W   = 12;
    localparam int SHELF_W = CRD_W + 1;
    localparam int SUM_W   = CRD_W + 2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_RESET    = 3'd2;
    localparam logic [2:0] ST_UNAVAIL  = 3'd3;
    localparam logic [2:0] ST_TOO_BIG  = 3'd4;

    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_ATLAS_W     = 2'd1;
    localparam logic [1:0] CFG_ATLAS_H     = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] w;
        logic [CRD_W-1:0] h;
    } t_entry;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MATCH,
        OP_HIT_MOVE,
        OP_TRIM,
        OP_CLEAR,
        OP_INSERT
    } t_op;

    typedef struct packed {
        logic             ok;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [SHELF_W-1:0] sx;
        logic [SHELF_W-1:0] sy;
        logic [SHELF_W-1:0] sh;
    } t_pack;

    // One shelf packing attempt; w and h already include the padding pixel.
    function automatic t_pack shelf_pack(
        input logic [SHELF_W-1:0] sx,
        input logic [SHELF_W-1:0] sy,
        input logic [SHELF_W-1:0] sh,
        input logic [SHELF_W-1:0] w,
        input logic [SHELF_W-1:0] h,
        input logic [CRD_W-1:0]   aw,
        input logic [CRD_W-1:0]   ah
    );
        t_pack            r;
        logic [SUM_W-1:0] nsx;
        logic [SUM_W-1:0] nsy;
        logic [SUM_W-1:0] nsh;
        r   = '0;
        r.ok = 1'b1;
        nsx = SUM_W'(sx);
        nsy = SUM_W'(sy);
        nsh = SUM_W'(sh);
        if (nsx + SUM_W'(w) > SUM_W'(aw)) begin
            nsx = SUM_W'(1);
            nsy = nsy + nsh + SUM_W'(1);
            nsh = '0;
            if (SUM_W'(1) + SUM_W'(w) > SUM_W'(aw)) begin
                r.ok = 1'b0;
            end
        end
        if (r.ok && (nsy + SUM_W'(h) > SUM_W'(ah))) begin
            r.ok = 1'b0;
        end
        if (r.ok) begin
            r.x = CRD_W'(nsx);
            r.y = CRD_W'(nsy);
            nsx = nsx + SUM_W'(w);
            if (SUM_W'(h) > nsh) begin
                nsh = SUM_W'(h);
            end
        end
        r.sx = SHELF_W'(nsx);
        r.sy = SHELF_W'(nsy);
        r.sh = SHELF_W'(nsh);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gclsp_cell.sv
// ============================================================================
// gclsp_cell: one entry of the recency-ordered chain
// Position in the chain is the recency rank; entries move one cell down
// when a newer entry is put in front of them.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gclsp_cell import gclsp_pkg::*; #(
    parameter int IW  = 8,
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_op              i_op,
    input  wire logic [IW-1:0]    i_pos,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_entry           i_prev,
    output      t_entry           o_entry,
    output      logic             o_match
);

    t_entry r_entry;
    logic   r_match;
    logic   w_load;

    always_comb begin
        w_load = (i_op == OP_INSERT) ||
                 ((i_op == OP_HIT_MOVE) && (IW'(IDX) <= i_pos));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            if (i_op == OP_MATCH) begin
                r_match <= r_entry.valid && (r_entry.key == i_key);
            end
            if (w_load) begin
                r_entry.valid <= i_prev.valid;
            end else if ((i_op == OP_CLEAR) ||
                         ((i_op == OP_TRIM) && (IW'(IDX) >= i_pos))) begin
                r_entry.valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_entry.key <= i_prev.key;
            r_entry.x   <= i_prev.x;
            r_entry.y   <= i_prev.y;
            r_entry.w   <= i_prev.w;
            r_entry.h   <= i_prev.h;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

`default_nettype wire

FILE: hdl/glyph_cache_lru_shelf_packer.sv
// ============================================================================
// glyph_cache_lru_shelf_packer: LRU glyph cache with shelf atlas packing
// Looks up a codepoint, evicts least recent entries and packs misses.
// ============================================================================
// A request is taken when i_start is high and o_busy is low. A hit or an
// unavailable miss runs S_LOOK, S_RED, S_DEC; an insert adds S_INS, with
// S_PK2 before it when the atlas has to be reset first. Lookup runs over a
// chain of CACHE_DEPTH cells ordered by recency: S_LOOK compares every cell,
// S_RED reduces the match into a hit position and entry, then the cells move.
// The result is shown on o_done for one cycle only and cannot be held off.
// Configuration writes are taken at any time but belong in idle.
`timescale 1ns / 1ps
`default_nettype none

module glyph_cache_lru_shelf_packer import gclsp_pkg::*; #(
    parameter int CACHE_DEPTH = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_addr,
    input  wire logic [11:0]      i_cfg_wdata,
    input  wire logic             i_start,
    output      logic             o_busy,
    input  wire logic [20:0]      i_codepoint,
    input  wire logic [11:0]      i_glyph_width,
    input  wire logic [11:0]      i_glyph_height,
    input  wire logic             i_glyph_available,
    output      logic             o_done,
    output      logic [2:0]       o_status,
    output      logic [11:0]      o_atlas_x,
    output      logic [11:0]      o_atlas_y,
    output      logic [11:0]      o_entry_width,
    output      logic [11:0]      o_entry_height
);

    localparam int IW = $clog2(CACHE_DEPTH);
    localparam int LW = $clog2(CACHE_DEPTH + 1);
    localparam int MW = (LW > 9) ? LW : 9;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_RED, S_DEC, S_PK2, S_INS} t_state;

    t_state            r_state;
    logic [8:0]        r_max_entries;
    logic [CRD_W-1:0]  r_atlas_w;
    logic [CRD_W-1:0]  r_atlas_h;
    logic [KEY_W-1:0]  r_cp;
    logic [CRD_W-1:0]  r_gw;
    logic [CRD_W-1:0]  r_gh;
    logic              r_avail;
    logic [LW-1:0]     r_occ;
    logic [SHELF_W-1:0] r_sx;
    logic [SHELF_W-1:0] r_sy;
    logic [SHELF_W-1:0] r_sh;
    logic              r_hit;
    logic [IW-1:0]     r_hit_pos;
    t_entry            r_hit_ent;
    logic [2:0]        r_st;
    logic [CRD_W-1:0]  r_px;
    logic [CRD_W-1:0]  r_py;

    t_entry            w_ent [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] w_match;
    t_op               w_op;
    logic [IW-1:0]     w_pos;
    t_entry            w_head;
    logic              w_hit;
    logic [IW-1:0]     w_hpos;
    t_entry            w_hent;
    logic [LW-1:0]     w_limit;
    logic [MW-1:0]     w_me;
    logic              w_zero;
    t_pack             w_pk;
    logic              n_done;

    // Limit clamped to 1..CACHE_DEPTH.
    always_comb begin
        w_me = MW'(r_max_entries);
        if (w_me == '0) begin
            w_limit = LW'(1);
        end else if (w_me > MW'(CACHE_DEPTH)) begin
            w_limit = LW'(CACHE_DEPTH);
        end else begin
            w_limit = LW'(w_me);
        end
    end

    // Keys are unique, so at most one cell matches: OR the gated entries.
    always_comb begin
        w_hit  = 1'b0;
        w_hpos = '0;
        w_hent = '0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (w_match[i]) begin
                w_hit  = 1'b1;
                w_hpos = w_hpos | IW'(i);
                w_hent = w_hent | w_ent[i];
            end
        end
    end

    assign w_zero = (r_gw == '0) || (r_gh == '0);
    assign w_pk   = shelf_pack(r_sx, r_sy, r_sh, SHELF_W'(r_gw) + SHELF_W'(1),
                               SHELF_W'(r_gh) + SHELF_W'(1), r_atlas_w, r_atlas_h);

    always_comb begin
        w_op   = OP_NOP;
        w_pos  = '0;
        w_head = '0;
        unique case (r_state)
            S_IDLE: w_op = OP_NOP;
            S_LOOK: w_op = OP_MATCH;
            S_RED:  w_op = OP_NOP;
            S_DEC: begin
                if (r_hit) begin
                    w_op         = OP_HIT_MOVE;
                    w_pos        = r_hit_pos;
                    w_head       = r_hit_ent;
                    w_head.valid = 1'b1;
                end else if (!r_avail) begin
                    w_op = OP_NOP;
                end else if (!w_zero && !w_pk.ok) begin
                    w_op = OP_CLEAR;
                end else if (r_occ >= w_limit) begin
                    w_op  = OP_TRIM;
                    w_pos = IW'(w_limit - LW'(1));
                end
            end
            S_PK2: begin
                if (!w_pk.ok) begin
                    w_op = OP_NOP;
                end
            end
            S_INS: begin
                w_op   = OP_INSERT;
                w_head = '{valid: 1'b1, key: r_cp, x: r_px, y: r_py, w: r_gw, h: r_gh};
            end
            default: w_op = OP_NOP;
        endcase
    end

    // Result strobe for the cycle after this edge.
    always_comb begin
        unique case (r_state)
            S_DEC:   n_done = r_hit || !r_avail;
            S_PK2:   n_done = !w_pk.ok;
            S_INS:   n_done = 1'b1;
            default: n_done = 1'b0;
        endcase
    end

    for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
        gclsp_cell #(.IW(IW), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_key   (r_cp),
            .i_prev  ((g == 0) ? w_head : w_ent[(g == 0) ? 0 : g - 1]),
            .o_entry (w_ent[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_max_entries <= 9'd256;
            r_atlas_w     <= 12'd1024;
            r_atlas_h     <= 12'd1024;
            r_occ         <= '0;
            r_sx          <= SHELF_W'(1);
            r_sy          <= SHELF_W'(1);
            r_sh          <= '0;
            o_done        <= 1'b0;
        end else begin
            o_done <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MAX_ENTRIES: r_max_entries <= i_cfg_wdata[8:0];
                    CFG_ATLAS_W:     r_atlas_w     <= i_cfg_wdata;
                    CFG_ATLAS_H:     r_atlas_h     <= i_cfg_wdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: r_state <= S_RED;
                S_RED:  r_state <= S_DEC;
                S_DEC: begin
                    if (r_hit) begin
                        o_status <= ST_HIT;
                        o_atlas_x      <= r_hit_ent.x;
                        o_atlas_y      <= r_hit_ent.y;
                        o_entry_width  <= r_hit_ent.w;
                        o_entry_height <= r_hit_ent.h;
                        r_state  <= S_IDLE;
                    end else if (!r_avail) begin
                        o_status <= ST_UNAVAIL;
                        o_atlas_x      <= '0;
                        o_atlas_y      <= '0;
                        o_entry_width  <= '0;
                        o_entry_height <= '0;
                        r_state  <= S_IDLE;
                    end else if (w_zero) begin
                        if (r_occ >= w_limit) begin
                            r_occ <= w_limit - LW'(1);
                        end
                        r_st    <= ST_INSERTED;
                        r_px    <= '0;
                        r_py    <= '0;
                        r_state <= S_INS;
                    end else if (w_pk.ok) begin
                        if (r_occ >= w_limit) begin
                            r_occ <= w_limit - LW'(1);
                        end
                        r_sx    <= w_pk.sx;
                        r_sy    <= w_pk.sy;
                        r_sh    <= w_pk.sh;
                        r_st    <= ST_INSERTED;
                        r_px    <= w_pk.x;
                        r_py    <= w_pk.y;
                        r_state <= S_INS;
                    end else begin
                        // Start the atlas over and retry once.
                        r_occ   <= '0;
                        r_sx    <= SHELF_W'(1);
                        r_sy    <= SHELF_W'(1);
                        r_sh    <= '0;
                        r_state <= S_PK2;
                    end
                end
                S_PK2: begin
                    r_sx <= w_pk.sx;
                    r_sy <= w_pk.sy;
                    r_sh <= w_pk.sh;
                    if (w_pk.ok) begin
                        r_st    <= ST_RESET;
                        r_px    <= w_pk.x;
                        r_py    <= w_pk.y;
                        r_state <= S_INS;
                    end else begin
                        o_status <= ST_TOO_BIG;
                        o_atlas_x      <= '0;
                        o_atlas_y      <= '0;
                        o_entry_width  <= '0;
                        o_entry_height <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_INS: begin
                    r_occ    <= r_occ + LW'(1);
                    o_status <= r_st;
                    o_atlas_x      <= r_px;
                    o_atlas_y      <= r_py;
                    o_entry_width  <= r_gw;
                    o_entry_height <= r_gh;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (r_state == S_IDLE && i_start) begin
            r_cp    <= i_codepoint;
            r_gw    <= i_glyph_width;
            r_gh    <= i_glyph_height;
            r_avail <= i_glyph_available;
        end
        if (r_state == S_RED) begin
            r_hit     <= w_hit;
            r_hit_pos <= w_hpos;
            r_hit_ent <= w_hent;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= LW'(CACHE_DEPTH))
        else $error("occupancy above cache depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result shown while still working");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("transfer did not start work");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_occ < w_limit))
        else $error("insert into full table");

endmodule

`default_nettype wire
